[hdl/bffha_pkg.sv]
// ----------------------------------------------------------------------------
// bffha_pkg
// shared constants and types for the bump / first-fit heap allocator
// ----------------------------------------------------------------------------
package bffha_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] ST_BUMP    = 3'd0;
  localparam logic [2:0] ST_REUSED  = 3'd1;
  localparam logic [2:0] ST_NOMEM   = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_POPPED  = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DONE,
    S_OUT
  } state_t;

  // record carried along the cell chain
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
    logic        is_free;
  } rec_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic             shift;
    logic             load;
    logic             set_free;
    logic             set_used;
    logic [IDX_W-1:0] load_idx;
    rec_t             load_rec;
  } cell_ctl_t;

endpackage

[hdl/bffha_cell.sv]
// ----------------------------------------------------------------------------
// bffha_cell
// one record slot of the rotating block table
// ----------------------------------------------------------------------------
module bffha_cell (
  input  logic                clk,
  input  bffha_pkg::cell_ctl_t ctl,
  input  logic [bffha_pkg::IDX_W-1:0] my_idx,
  input  logic                head,
  input  bffha_pkg::rec_t     rec_in,
  output bffha_pkg::rec_t     rec_out
);

  bffha_pkg::rec_t rec_r;
  bffha_pkg::rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.shift) begin
      rec_nxt = rec_in;
      if (head && ctl.set_free) begin
        rec_nxt.is_free = 1'b1;
      end
      if (head && ctl.set_used) begin
        rec_nxt.is_free = 1'b0;
      end
    end else if (ctl.load && ctl.load_idx == my_idx) begin
      rec_nxt = ctl.load_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_out = rec_r;

endmodule

[hdl/bump_first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// bump_first_fit_heap_allocator_core
// heap allocator: bump pointer first, first-fit reuse over a record chain
// ----------------------------------------------------------------------------
// A bump allocate, a pop of the last block, an out-of-range free and a free
// to an empty table each pass once through the load, scan, done and out
// states. A reuse search, a failed allocate or any other free rotates the
// whole chain of MAX_BLOCKS record cells once, one cell per cycle, in
// the scan state. One request is handled at a time; the next request is
// taken from the cycle after the result is presented, unless that result is
// still stalled in the output register.
module bump_first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_data_address,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned N = bffha_pkg::MAX_BLOCKS;
  localparam int unsigned IW = bffha_pkg::IDX_W;
  localparam int unsigned CW = bffha_pkg::CNT_W;

  bffha_pkg::state_t state_r, state_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] bump_r, bump_nxt;
  logic        op_r, op_nxt;
  logic [31:0] req_r, req_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic        found_r, found_nxt;
  logic        fit_r, fit_nxt;
  logic        range_r, range_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic [2:0]  res_st_r, res_st_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [31:0] last_addr_r, last_addr_nxt;

  bffha_pkg::cell_ctl_t ctl;
  bffha_pkg::rec_t      recs [N];
  bffha_pkg::rec_t      head;
  logic                 head_hit;
  logic [33:0]          need;
  logic [32:0]          top;

  assign head = recs[0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      bffha_pkg::rec_t nb;
      if (g == N - 1) begin : g_wrap
        assign nb = recs[0];
      end else begin : g_mid
        assign nb = recs[g+1];
      end
      bffha_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .my_idx (IW'(g)),
        .head   (g == N - 1),
        .rec_in (nb),
        .rec_out(recs[g])
      );
    end
  endgenerate

  assign in_stall  = (state_r != bffha_pkg::S_IDLE) || (ov_r && out_stall);
  assign cfg_ready = (state_r == bffha_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data_address = od_r;
  assign out_status = os_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffha_pkg::S_IDLE;
      base_r  <= '0;
      bytes_r <= 32'd4194304;
      count_r <= '0;
      bump_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      bytes_r <= bytes_nxt;
      count_r <= count_nxt;
      bump_r  <= bump_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    req_r <= req_nxt;
    addr_r <= addr_nxt;
    step_r <= step_nxt;
    found_r <= found_nxt;
    fit_r <= fit_nxt;
    range_r <= range_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r <= res_st_nxt;
    od_r <= od_nxt;
    os_r <= os_nxt;
    last_addr_r <= last_addr_nxt;
  end

  // chain head is record 0 after every full rotation
  always_comb begin
    head_hit = 1'b0;
    if (step_r < count_r && !found_r) begin
      if (op_r == bffha_pkg::OP_ALLOC) begin
        head_hit = head.is_free && (head.size >= req_r);
      end else begin
        head_hit = (head.addr == addr_r);
      end
    end
  end

  assign need = {2'b0, bump_r} + 34'(bffha_pkg::HEADER_BYTES) + {2'b0, req_r};
  assign top  = {1'b0, base_r} + {1'b0, bytes_r};

  always_comb begin
    state_nxt = state_r;
    base_nxt = base_r;
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    bump_nxt = bump_r;
    op_nxt = op_r;
    req_nxt = req_r;
    addr_nxt = addr_r;
    step_nxt = step_r;
    found_nxt = found_r;
    fit_nxt = fit_r;
    range_nxt = range_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt = res_st_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    os_nxt = os_r;
    last_addr_nxt = last_addr_r;
    ctl = '0;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      bffha_pkg::S_IDLE: begin
        if (cfg_valid) begin
          unique case (cfg_index)
            bffha_pkg::CFG_HEAP_BASE:  base_nxt = cfg_data;
            bffha_pkg::CFG_HEAP_BYTES: bytes_nxt = cfg_data;
            default: ;
          endcase
        end
        if (in_valid && !in_stall) begin
          op_nxt = in_opcode;
          req_nxt = in_request_size;
          addr_nxt = in_address;
          state_nxt = bffha_pkg::S_LOAD;
        end
      end
      bffha_pkg::S_LOAD: begin
        fit_nxt = (count_r < CW'(N)) && (need <= {2'b0, bytes_r});
        range_nxt = (addr_r >= base_r) && ({1'b0, addr_r} <= top) && (count_r != '0);
        last_addr_nxt = recs[IW'(count_r - CW'(1))].addr;
        step_nxt = '0;
        found_nxt = 1'b0;
        res_addr_nxt = '0;
        state_nxt = bffha_pkg::S_SCAN;
      end
      bffha_pkg::S_SCAN: begin
        if (op_r == bffha_pkg::OP_ALLOC && fit_r) begin
          ctl.load = 1'b1;
          ctl.load_idx = IW'(count_r);
          ctl.load_rec.addr = base_r + bump_r + 32'(bffha_pkg::HEADER_BYTES);
          ctl.load_rec.size = req_r;
          ctl.load_rec.is_free = 1'b0;
          res_addr_nxt = ctl.load_rec.addr;
          res_st_nxt = bffha_pkg::ST_BUMP;
          count_nxt = count_r + CW'(1);
          bump_nxt = need[31:0];
          state_nxt = bffha_pkg::S_DONE;
        end else if (op_r == bffha_pkg::OP_FREE && !range_r) begin
          res_st_nxt = bffha_pkg::ST_IGNORED;
          state_nxt = bffha_pkg::S_DONE;
        end else if (op_r == bffha_pkg::OP_FREE && last_addr_r == addr_r) begin
          count_nxt = count_r - CW'(1);
          bump_nxt = addr_r - 32'(bffha_pkg::HEADER_BYTES) - base_r;
          res_st_nxt = bffha_pkg::ST_POPPED;
          state_nxt = bffha_pkg::S_DONE;
        end else begin
          ctl.shift = 1'b1;
          if (head_hit) begin
            found_nxt = 1'b1;
            if (op_r == bffha_pkg::OP_ALLOC) begin
              ctl.set_used = 1'b1;
              res_addr_nxt = head.addr;
            end else begin
              ctl.set_free = 1'b1;
            end
          end
          step_nxt = step_r + CW'(1);
          if (step_r == CW'(N - 1)) begin
            if (op_r == bffha_pkg::OP_ALLOC) begin
              res_st_nxt = (found_r || head_hit) ? bffha_pkg::ST_REUSED : bffha_pkg::ST_NOMEM;
            end else begin
              res_st_nxt = (found_r || head_hit) ? bffha_pkg::ST_FREED
                                                 : bffha_pkg::ST_IGNORED;
            end
            state_nxt = bffha_pkg::S_DONE;
          end
        end
      end
      bffha_pkg::S_DONE: begin
        state_nxt = bffha_pkg::S_OUT;
      end
      bffha_pkg::S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = res_addr_r;
          os_nxt = res_st_r;
          state_nxt = bffha_pkg::S_IDLE;
        end
      end
      default: state_nxt = bffha_pkg::S_IDLE;
    endcase
  end

endmodule

[sim/heap_alloc_checker.sv]
// ----------------------------------------------------------------------------
// heap_alloc_checker
// watches the request and result channels of the heap allocator, keeps its
// own copy of the block table, bump pointer and heap registers, and compares
// every result with the predicted address and status in order
// ----------------------------------------------------------------------------
module heap_alloc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_data_address,
  input  logic [2:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] data_address;
    logic [2:0]  status;
  } alloc_result_t;

  logic [31:0] base_q, bytes_q, bump_q;
  logic [31:0] rec_addr [bffha_pkg::MAX_BLOCKS];
  logic [31:0] rec_size [bffha_pkg::MAX_BLOCKS];
  logic        rec_free [bffha_pkg::MAX_BLOCKS];
  int unsigned rec_count;
  alloc_result_t expected_results[$];

  function automatic alloc_result_t heap_step(logic op, logic [31:0] req, logic [31:0] addr);
    alloc_result_t r;
    logic [33:0] need;
    logic [32:0] top;
    int i;
    if (op == bffha_pkg::OP_ALLOC) begin
      need = {2'b0, bump_q} + 34'(bffha_pkg::HEADER_BYTES) + {2'b0, req};
      if (rec_count < bffha_pkg::MAX_BLOCKS && need <= {2'b0, bytes_q}) begin
        r.data_address = base_q + bump_q + 32'(bffha_pkg::HEADER_BYTES);
        rec_addr[rec_count] = r.data_address;
        rec_size[rec_count] = req;
        rec_free[rec_count] = 1'b0;
        rec_count++;
        bump_q = need[31:0];
        r.status = bffha_pkg::ST_BUMP;
        return r;
      end
      for (i = 0; i < rec_count; i++) begin
        if (rec_free[i] && rec_size[i] >= req) begin
          rec_free[i] = 1'b0;
          r.data_address = rec_addr[i];
          r.status = bffha_pkg::ST_REUSED;
          return r;
        end
      end
      r.data_address = '0;
      r.status = bffha_pkg::ST_NOMEM;
      return r;
    end
    r.data_address = '0;
    r.status = bffha_pkg::ST_IGNORED;
    top = {1'b0, base_q} + {1'b0, bytes_q};
    if (addr < base_q || {1'b0, addr} > top || rec_count == 0) return r;
    if (rec_addr[rec_count-1] == addr) begin
      rec_count--;
      bump_q = addr - 32'(bffha_pkg::HEADER_BYTES) - base_q;
      r.status = bffha_pkg::ST_POPPED;
      return r;
    end
    for (i = 0; i < rec_count; i++) begin
      if (rec_addr[i] == addr) begin
        rec_free[i] = 1'b1;
        r.status = bffha_pkg::ST_FREED;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst_n) begin
      base_q = '0;
      bytes_q = 32'd4194304;
      bump_q = '0;
      rec_count = 0;
      fail_count = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bffha_pkg::CFG_HEAP_BASE) base_q = cfg_data;
        else bytes_q = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(heap_step(in_opcode, in_request_size, in_address));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result addr=%h status=%0d",
                                         out_data_address, out_status);
        end else begin
          e = expected_results.pop_front();
          if (e.data_address !== out_data_address || e.status !== out_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                       e.data_address, e.status, out_data_address, out_status);
          end
        end
      end
      pending = expected_results.size();
    end
  end
endmodule

[sim/tb_bump_first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_bump_first_fit_heap_allocator_core
// drives directed and random allocate/free requests through several heap
// settings with random idling and back pressure; the checker scores results
// ----------------------------------------------------------------------------
module tb_bump_first_fit_heap_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0, in_stall;
  logic        in_opcode = bffha_pkg::OP_ALLOC;
  logic [31:0] in_request_size = '0, in_address = '0;
  logic        out_valid, out_stall = 1'b0;
  logic [31:0] out_data_address;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0, cfg_ready, cfg_index = bffha_pkg::CFG_HEAP_BASE;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;
  logic [31:0] live_addrs[$];
  logic [31:0] cur_base = '0;

  always #5 clk = ~clk;

  bump_first_fit_heap_allocator_core dut (.*);
  heap_alloc_checker checker_i (.*);

  // result side idling
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else begin
        w = $urandom_range(0, 3);
        if (stim_done || $urandom_range(0, 3) == 0) w = 0;
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 1'b0;
        if (!hold_off) @(posedge clk iff out_valid);
      end
    end
  end

  always @(posedge clk) if (out_valid && !out_stall && out_status <= bffha_pkg::ST_REUSED)
    live_addrs.push_back(out_data_address);

  // valid stays high after an accept until the next request or a pause
  task automatic send_request(logic op, logic [31:0] req, logic [31:0] addr, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 3) : 0;
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_request_size <= req;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    repeat (bffha_pkg::MAX_BLOCKS + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bffha_pkg::CFG_HEAP_BASE) cur_base = val;
  endtask

  task automatic random_phase(int n, int small_max);
    logic [31:0] a;
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 5)
        send_request(bffha_pkg::OP_ALLOC,
                     ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, small_max),
                     $urandom, k % 50 < 40);
      else begin
        if (live_addrs.size() != 0 && $urandom_range(0, 4) != 0)
          a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        else if ($urandom_range(0, 1)) a = cur_base + $urandom_range(0, 4096);
        else a = $urandom;
        send_request(bffha_pkg::OP_FREE, $urandom, a, k % 50 < 40);
      end
    end
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    send_request(bffha_pkg::OP_FREE, '0, 32'd20, 1'b0);
    send_request(bffha_pkg::OP_ALLOC, '0, '0, 1'b0);
    send_request(bffha_pkg::OP_ALLOC, 32'd100, '1, 1'b0);
    send_request(bffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0, 1'b0);
    send_request(bffha_pkg::OP_ALLOC, 32'd8, '0, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd40, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd40, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd12345, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'hFFFF_FFFF, 1'b0);
    send_request(bffha_pkg::OP_FREE, '1, 32'd168, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd148, 1'b0);
    send_request(bffha_pkg::OP_ALLOC, 32'd10, '0, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd20, 1'b0);
    send_request(bffha_pkg::OP_FREE, '0, 32'd40, 1'b0);
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'd400);
    for (i = 0; i < 8; i++) send_request(bffha_pkg::OP_ALLOC, 32'd20 + i, '0, 1'b1);
    send_request(bffha_pkg::OP_FREE, '0, 32'd60, 1'b1);
    send_request(bffha_pkg::OP_ALLOC, 32'd30, '0, 1'b1);
    send_request(bffha_pkg::OP_ALLOC, 32'd22, '0, 1'b1);
    // table full
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'hFFFF_FFFF);
    for (i = 0; i < 66; i++) send_request(bffha_pkg::OP_ALLOC, i[31:0], '0, 1'b0);
    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 1'b0; end
      random_phase(20, 64);
    join
    drain();
    random_phase(300, 64);
    write_reg(bffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'd2000);
    live_addrs.delete();
    random_phase(300, 200);
    write_reg(bffha_pkg::CFG_HEAP_BASE, 32'h0001_0000);
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'd0);
    random_phase(100, 64);
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'd1200);
    live_addrs.delete();
    random_phase(400, 100);
    write_reg(bffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(bffha_pkg::CFG_HEAP_BYTES, 32'd300000);
    live_addrs.delete();
    random_phase(300, 9000);
    stim_done = 1'b1;
    drain();
    repeat (bffha_pkg::MAX_BLOCKS + 8) @(posedge clk);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[sim.f]
hdl/bffha_pkg.sv
hdl/bffha_cell.sv
hdl/bump_first_fit_heap_allocator_core.sv
sim/heap_alloc_checker.sv
sim/tb_bump_first_fit_heap_allocator_core.sv
